[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tsd_pkg.sv]
// Types and constants of the scaled-target divider.
package tsd_pkg;

  localparam int WORD_W  = 64;
  localparam int TGT_W   = 256;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = TGT_W + SCALE_W;   // product of target and scale
  localparam int DIV_W   = 63;                // clamped divisor stays below 2^63
  localparam int N_PP    = TGT_W / SCALE_W;   // 32-bit slices of the target

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd1000000;

  // Beat moving down the divider chain.
  typedef struct packed {
    logic              vld;
    logic              szero;
    logic [DIV_W-1:0]  d;
    logic [DIV_W-1:0]  rem;
    logic [PROD_W-1:0] nq;   // numerator bits shift out the top, quotient bits in the bottom
  } tsd_cell_t;

endpackage

[src/tsd_if.sv]
// Valid/ready channel interfaces for requests and results.
interface tsd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] target_in_word0;
  logic [63:0] target_in_word1;
  logic [63:0] target_in_word2;
  logic [63:0] target_in_word3;
  logic signed [63:0] multiplier;

  modport source (
    output valid, target_in_word0, target_in_word1, target_in_word2, target_in_word3,
           multiplier,
    input  ready
  );
  modport sink (
    input  valid, target_in_word0, target_in_word1, target_in_word2, target_in_word3,
           multiplier,
    output ready
  );
endinterface

interface tsd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] target_out_word0;
  logic [63:0] target_out_word1;
  logic [63:0] target_out_word2;
  logic [63:0] target_out_word3;

  modport source (
    output valid, target_out_word0, target_out_word1, target_out_word2, target_out_word3,
    input  ready
  );
  modport sink (
    input  valid, target_out_word0, target_out_word1, target_out_word2, target_out_word3,
    output ready
  );
endinterface

[src/tsd_div_cell.sv]
// One restoring-division step: shift in a numerator bit, compare, subtract.
module tsd_div_cell
  import tsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  tsd_cell_t prv,
  output tsd_cell_t cur_r
);

  tsd_cell_t        cur_nxt;
  logic [WORD_W-1:0] trial;
  logic [WORD_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {prv.rem, prv.nq[PROD_W-1]};
    diff  = {1'b0, trial} - {2'b00, prv.d};
    ge    = !diff[WORD_W];
    cur_nxt       = prv;
    cur_nxt.rem   = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    cur_nxt.nq    = {prv.nq[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.vld <= 1'b0;
    end else if (adv) begin
      cur_r.vld <= cur_nxt.vld;
    end
    if (adv) begin
      cur_r.szero <= cur_nxt.szero;
      cur_r.d     <= cur_nxt.d;
      cur_r.rem   <= cur_nxt.rem;
      cur_r.nq    <= cur_nxt.nq;
    end
  end

endmodule

[src/tsd_scale_mult.sv]
// Front end: clamp the multiplier, form the target-times-scale product in two stages.
module tsd_scale_mult
  import tsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [SCALE_W-1:0] scale,
  tsd_in_if.sink             in_ch,
  output tsd_cell_t          prod_r
);

  logic [WORD_W-1:0] pp_r   [N_PP];
  logic [WORD_W-1:0] pp_nxt [N_PP];
  logic [DIV_W-1:0]  d_r, d_nxt;
  logic              sz_r, a_vld_r;
  logic [TGT_W-1:0]  tgt;
  logic [WORD_W-1:0] mu;
  logic [TGT_W-1:0]  even, odd;
  logic [PROD_W-1:0] prod_nxt;

  assign in_ch.ready = adv;

  always_comb begin
    tgt = {in_ch.target_in_word3, in_ch.target_in_word2,
           in_ch.target_in_word1, in_ch.target_in_word0};
    mu  = in_ch.multiplier;
    for (int i = 0; i < N_PP; i++) begin
      pp_nxt[i] = WORD_W'(tgt[SCALE_W*i +: SCALE_W]) * WORD_W'(scale);
    end
    // negative or below-scale multipliers fall back to the scale
    if (mu[WORD_W-1] || (mu < {{(WORD_W-SCALE_W){1'b0}}, scale})) begin
      d_nxt = {{(DIV_W-SCALE_W){1'b0}}, scale};
    end else begin
      d_nxt = mu[DIV_W-1:0];
    end
  end

  always_comb begin
    even = '0;
    odd  = '0;
    for (int i = 0; i < N_PP / 2; i++) begin
      even[WORD_W*i +: WORD_W] = pp_r[2*i];
      odd[WORD_W*i +: WORD_W]  = pp_r[2*i+1];
    end
    prod_nxt = {{SCALE_W{1'b0}}, even} + {odd, {SCALE_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= 1'b0;
      prod_r.vld <= 1'b0;
    end else if (adv) begin
      a_vld_r    <= in_ch.valid;
      prod_r.vld <= a_vld_r;
    end
    if (adv) begin
      for (int i = 0; i < N_PP; i++) begin
        pp_r[i] <= pp_nxt[i];
      end
      d_r          <= d_nxt;
      sz_r         <= (scale == '0);
      prod_r.szero <= sz_r;
      prod_r.d     <= d_r;
      prod_r.rem   <= '0;
      prod_r.nq    <= prod_nxt;
    end
  end

endmodule

[src/tsd_out_skid.sv]
// Two-entry result buffer; it frees the pipeline while the consumer stalls.
module tsd_out_skid
  import tsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [TGT_W-1:0] push_data,
  output logic             adv,
  tsd_out_if.source        out_ch
);

  logic [1:0]       cnt_r, cnt_nxt;
  logic [TGT_W-1:0] e0_r, e0_nxt, e1_r, e1_nxt;
  logic             pop;

  assign adv          = (cnt_r != 2'd2);
  assign out_ch.valid = (cnt_r != 2'd0);
  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.target_out_word0 = e0_r[WORD_W*0 +: WORD_W];
  assign out_ch.target_out_word1 = e0_r[WORD_W*1 +: WORD_W];
  assign out_ch.target_out_word2 = e0_r[WORD_W*2 +: WORD_W];
  assign out_ch.target_out_word3 = e0_r[WORD_W*3 +: WORD_W];

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          e0_nxt  = push_data;
          cnt_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          e0_nxt = push_data;
        end else if (push) begin
          e1_nxt  = push_data;
          cnt_nxt = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      default: begin
        // full: no push can arrive, drain the head
        if (pop) begin
          e0_nxt  = e1_r;
          cnt_nxt = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

[src/target_scale_by_fixed_point_divisor_top.sv]
// Scaled-target divider: one request per clock cycle, result
// floor(target * scale / max(multiplier, scale)), forced to 1 when zero or when the
// scale is zero. The block accepts a beat every cycle while its two-entry result
// buffer has room; from acceptance a request passes through the scale multiply
// and product sum stages, then through each of the 288 division cells (one
// quotient bit per cell over the 288-bit product), then the result buffer.
// The scale register is sampled by each request as it enters.
module target_scale_by_fixed_point_divisor_top
  import tsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  tsd_in_if.sink             in_ch,
  tsd_out_if.source          out_ch
);

  logic [SCALE_W-1:0] scale_r;
  logic               adv;
  tsd_cell_t          chain [PROD_W+1];
  logic [TGT_W-1:0]   quo;
  logic [TGT_W-1:0]   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  tsd_scale_mult u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .scale  (scale_r),
    .in_ch  (in_ch),
    .prod_r (chain[0])
  );

  for (genvar g = 0; g < PROD_W; g++) begin : g_cell
    tsd_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .prv   (chain[g]),
      .cur_r (chain[g+1])
    );
  end

  // quotient never exceeds the target, so the top product bits hold zeros
  assign quo = chain[PROD_W].nq[TGT_W-1:0];
  assign res = (chain[PROD_W].szero || (quo == '0)) ? {{(TGT_W-1){1'b0}}, 1'b1} : quo;

  tsd_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && chain[PROD_W].vld),
    .push_data (res),
    .adv       (adv),
    .out_ch    (out_ch)
  );

endmodule

[src/tsd_checker.sv]
// Port-level checks of the scaled-target divider and their bind.
`include "assert_macros.svh"

module tsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_w0,
  input logic [63:0] out_w1,
  input logic [63:0] out_w2,
  input logic [63:0] out_w3
);

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_w0) && $stable(out_w3), "stalled result beat changed")
  `ASSERT_CLK(a_nonzero, out_valid |-> ((out_w0 | out_w1 | out_w2 | out_w3) != 64'd0), "zero result offered")
  `ASSERT_CLK(a_empty_ready, !out_valid |-> in_ready, "input stalled with empty result buffer")
  `ASSERT_RST(a_reset_clear, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind target_scale_by_fixed_point_divisor_top tsd_checker u_tsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_w0    (out_ch.target_out_word0),
  .out_w1    (out_ch.target_out_word1),
  .out_w2    (out_ch.target_out_word2),
  .out_w3    (out_ch.target_out_word3)
);

[tb/tb_target_scale_by_fixed_point_divisor_top.sv]
// Self-checking testbench for the scaled-target divider top level.
module tb_target_scale_by_fixed_point_divisor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsd_pkg::*;

  localparam int STALL_LIMIT  = 5000;  // cycles without any beat before giving up
  localparam int SETTLE_WAIT  = 300;   // outlasts the path of a request through the pipeline
  localparam int PHASE_ITEMS  = 125;
  localparam int LAST_PHASE   = 8;

  typedef struct packed {
    logic [TGT_W-1:0]  target;
    logic [WORD_W-1:0] multiplier;   // two's complement
  } request_t;

  logic               clk;
  logic               rst_n_q     = 1'b0;
  logic               cfg_we_q    = 1'b0;
  logic [SCALE_W-1:0] cfg_wdata_q = '0;
  logic               drv_valid   = 1'b0;
  request_t           drv_req     = '0;
  logic               rcv_ready   = 1'b0;

  request_t           request_q[$];
  logic [TGT_W-1:0]   target_due_q[$];
  logic [SCALE_W-1:0] scale_now = SCALE_RESET;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 sent_n  = 0;
  int                 taken_n = 0;
  int                 fail_n  = 0;
  int                 quiet_cycles = 0;

  tsd_in_if  in_ch();
  tsd_out_if out_ch();

  assign in_ch.valid           = drv_valid;
  assign in_ch.target_in_word0 = drv_req.target[63:0];
  assign in_ch.target_in_word1 = drv_req.target[127:64];
  assign in_ch.target_in_word2 = drv_req.target[191:128];
  assign in_ch.target_in_word3 = drv_req.target[255:192];
  assign in_ch.multiplier      = drv_req.multiplier;
  assign out_ch.ready          = rcv_ready;

  target_scale_by_fixed_point_divisor_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n_q),
    .cfg_we    (cfg_we_q),
    .cfg_wdata (cfg_wdata_q),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // floor(target * scale / max(multiplier, scale)), never below 1
  function automatic logic [TGT_W-1:0] scaled_target(request_t r, logic [SCALE_W-1:0] s);
    logic [319:0] product;
    logic [319:0] divisor;
    logic [319:0] quotient;
    if (s == '0) return 256'd1;
    if (r.multiplier[63] || r.multiplier[62:0] < 63'(s)) divisor = 320'(s);
    else divisor = 320'(r.multiplier[62:0]);
    product  = 320'(r.target) * 320'(s);
    quotient = product / divisor;
    if (quotient[255:0] == '0) return 256'd1;
    return quotient[255:0];
  endfunction

  function automatic request_t random_request(logic [SCALE_W-1:0] s);
    request_t    r;
    logic [255:0] t;
    logic [63:0]  x;
    t = {rand64(), rand64(), rand64(), rand64()};
    x = rand64();
    case ($urandom_range(4))
      0:       r.target = t;
      1:       r.target = t >> $urandom_range(255);
      2:       r.target = 256'(t[63:0] >> $urandom_range(63));
      3:       r.target = {t[255:128] >> $urandom_range(127), t[127:0]};
      default: r.target = ($urandom_range(1) != 0) ? '1 : '0;
    endcase
    case ($urandom_range(5))
      0:       r.multiplier = x | 64'h8000_0000_0000_0000;
      1:       r.multiplier = (s == '0) ? 64'd0 : x % 64'(s);
      2:       r.multiplier = 64'(s) + 64'($urandom_range(3));
      3:       r.multiplier = 64'(s) * 64'($urandom_range(1000, 1));
      4:       r.multiplier = {1'b0, x[62:0]} >> $urandom_range(62);
      default: r.multiplier = x;
    endcase
    return r;
  endfunction

  task automatic push_request(logic [TGT_W-1:0] t, logic [WORD_W-1:0] m);
    request_t r;
    r.target     = t;
    r.multiplier = m;
    request_q = {request_q, r};
  endtask

  // Source side: hold a beat until taken, otherwise maybe idle; also drive result ready at random.
  always @(negedge clk) begin
    if (rst_n_q && !(drv_valid && sent_n != taken_n)) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_req   <= request_q[0];
        request_q.delete(0);
        drv_valid <= 1'b1;
        sent_n++;
      end else begin
        drv_valid <= 1'b0;
      end
    end
    rcv_ready <= rst_n_q && ($urandom_range(99) >= recv_idle_pct);
  end

  // Sample both channels, predict, compare, and watch for a hang.
  always @(posedge clk) begin
    logic [TGT_W-1:0] due;
    logic [TGT_W-1:0] got;
    request_t         seen;
    if (rst_n_q) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.target = {in_ch.target_in_word3, in_ch.target_in_word2,
                       in_ch.target_in_word1, in_ch.target_in_word0};
        seen.multiplier = in_ch.multiplier;
        target_due_q = {target_due_q, scaled_target(seen, scale_now)};
        taken_n++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.target_out_word3, out_ch.target_out_word2,
               out_ch.target_out_word1, out_ch.target_out_word0};
        if (target_due_q.size() == 0) begin
          $error("result beat with nothing outstanding: %h", got);
          fail_n++;
        end else begin
          due = target_due_q[0];
          target_due_q.delete(0);
          for (int k = 0; k < 4; k++) begin
            if (got[k*64 +: 64] !== due[k*64 +: 64]) begin
              $error("target_out_word%0d: expected %h, actual %h", k,
                     due[k*64 +: 64], got[k*64 +: 64]);
              fail_n++;
            end
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [SCALE_W-1:0] s;
    logic [63:0]        sr;
    sr = 64'(SCALE_RESET);
    repeat (5) @(negedge clk);
    rst_n_q <= 1'b1;

    for (int p = 0; p <= LAST_PHASE; p++) begin
      // receiver-heavy stalls, then sender-heavy, then none
      if (p < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 47;
      end else if (p < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (p == 0) begin
        push_request('0, sr);
        push_request('1, sr);
        push_request('1, 64'h8000_0000_0000_0000);
        push_request('1, '1);
        push_request('1, 64'd0);
        push_request('1, sr - 1);
        push_request('1, sr + 1);
        push_request('1, 64'h7FFF_FFFF_FFFF_FFFF);
        push_request(256'd1, 64'h7FFF_FFFF_FFFF_FFFF);
        push_request(256'd1, sr);
        push_request(256'd1 << 255, sr * 2);
        push_request({4{64'hAAAA_AAAA_AAAA_AAAA}}, 64'h5555_5555_5555_5555);
        push_request({4{64'h5555_5555_5555_5555}}, sr * 3);
        push_request({64'hFFFF_FFFF_FFFF_FFFF, 192'h0}, sr * 7);
        push_request('0, 64'h8000_0000_0000_0000);
        push_request(256'd999999, sr * 2);
        push_request('1, sr * 1000);
      end else begin
        case (p)
          1:       s = 32'd1;
          2:       s = 32'hFFFF_FFFF;
          3:       s = 32'd0;
          5:       s = SCALE_RESET;
          7:       s = 32'd2;
          default: s = $urandom >> $urandom_range(31);
        endcase
        @(negedge clk);
        cfg_wdata_q <= s;
        cfg_we_q    <= 1'b1;
        @(negedge clk);
        cfg_we_q    <= 1'b0;
        scale_now    = s;
        for (int k = 0; k < PHASE_ITEMS; k++) request_q = {request_q, random_request(s)};
      end

      // drain fully before the next register write
      wait (request_q.size() == 0 && sent_n == taken_n && target_due_q.size() == 0);
      @(negedge clk);
    end

    repeat (SETTLE_WAIT) @(posedge clk);
    if (fail_n == 0 && target_due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
